// File: hdl/sha1h_pkg.sv
// Shared types, constants and helper functions for the SHA-1 message hasher.
// No dependencies; imported by the interfaces' users, the round unit and the top level.
package sha1h_pkg;

  localparam int unsigned CHAIN_WORDS = 5;
  localparam int unsigned ROUNDS      = 80;
  localparam int unsigned SCHED_WORDS = 16;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Control from the sequencer to the round unit
  typedef struct packed {
    logic       shift;     // shift working words, new word enters at e
    logic       step;      // perform one compression round
    logic [6:0] round_idx; // current round, 0..79
  } sha1h_ctl_t;

  // Initial chaining value for one word position
  function automatic logic [31:0] init_word(input logic [2:0] idx);
    logic [31:0] w;
    case (idx)
      3'd0:    w = H0;
      3'd1:    w = H1;
      3'd2:    w = H2;
      3'd3:    w = H3;
      3'd4:    w = H4;
      default: w = '0;
    endcase
    return w;
  endfunction

  // Round constant by round number
  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] k;
    if (r < 7'd20)      k = K0;
    else if (r < 7'd40) k = K1;
    else if (r < 7'd60) k = K2;
    else                k = K3;
    return k;
  endfunction

endpackage

// File: hdl/sha1h_if.sv
// Handshake interfaces for the message byte channel and the digest word channel.
// No dependencies.
interface sha1h_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] message_byte;
  logic       byte_valid;
  logic       end_of_message;

  modport source (output valid, message_byte, byte_valid, end_of_message, input ready);
  modport sink   (input valid, message_byte, byte_valid, end_of_message, output ready);
endinterface

interface sha1h_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: hdl/sha1h_round_unit.sv
// SHA-1 round datapath: working words a..e and the 16-word schedule window.
// Depends on sha1h_pkg; driven by the sequencer in sha1_message_hasher_top.
module sha1h_round_unit import sha1h_pkg::*; (
  input  logic        clk,
  input  sha1h_ctl_t  ctl,
  input  logic [31:0] shift_data,
  input  logic [31:0] msg_word,
  output logic [31:0] a_word
);

  logic [31:0] a, b, c, d, e;
  logic [31:0] win [SCHED_WORDS];
  logic [31:0] sched_x;
  logic [31:0] w_cur;
  logic [31:0] f;
  logic [31:0] t;

  // Message word: the msg_word input for the first 16 rounds, else expanded
  always_comb begin
    sched_x = win[13] ^ win[8] ^ win[2] ^ win[0];
    if (ctl.round_idx < 7'(SCHED_WORDS)) begin
      w_cur = msg_word;
    end else begin
      w_cur = {sched_x[30:0], sched_x[31]};
    end
  end

  // Round function
  always_comb begin
    if (ctl.round_idx < 7'd20) begin
      f = (b & c) | (~b & d);
    end else if (ctl.round_idx < 7'd40) begin
      f = b ^ c ^ d;
    end else if (ctl.round_idx < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    t = {a[26:0], a[31:27]} + f + e + round_k(ctl.round_idx) + w_cur;
  end

  // Working words: load/unload by shifting, or one round
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      a <= b;
      b <= c;
      c <= d;
      d <= e;
      e <= shift_data;
    end else if (ctl.step) begin
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= t;
    end
  end

  // Schedule window, newest word at the top
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      for (int i = 0; i < SCHED_WORDS - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[SCHED_WORDS-1] <= w_cur;
    end
  end

  assign a_word = a;

endmodule

// File: hdl/sha1_message_hasher_top.sv
// Top level of the SHA-1 message hasher: byte packing, padding, sequencing,
// block and chaining memories. Depends on sha1h_pkg, sha1h_if and sha1h_round_unit.
//
//  channel  | dir | payload                                   | notes
//  ---------+-----+-------------------------------------------+-------------------------
//  msg      | in  | message_byte[7:0] byte_valid end_of_message | at most one byte per item
//  digest   | out | digest_word[31:0] word_index[2:0] last_word | five items per message
//
// An item is taken only while the sequencer is idle, so never while a block is being compressed.
// Each block loads the chaining words from their memory into the round unit, runs
// 80 rounds on the single round unit, then adds and writes the chaining words back.
// An ending item adds a padding setup state, one or two blocks, then a read and a show state per digest word.
// Synchronous reset; no item is taken while a block runs or the digest is out,
// and a stalled digest word is held until taken.
module sha1_message_hasher_top import sha1h_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  sha1h_msg_if.sink             msg,
  sha1h_digest_if.source        digest
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_WB    = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;
  localparam logic [2:0] S_SHOW  = 3'd6;

  // What follows the block now being compressed
  localparam logic [1:0] NX_IDLE   = 2'd0;
  localparam logic [1:0] NX_PAD    = 2'd1;
  localparam logic [1:0] NX_SECOND = 2'd2;
  localparam logic [1:0] NX_OUT    = 2'd3;

  localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);
  localparam logic [6:0] XFER_END   = 7'(CHAIN_WORDS);
  localparam logic [2:0] LAST_IDX   = 3'(CHAIN_WORDS - 1);

  logic [2:0]  state;
  logic [6:0]  cnt;
  logic [1:0]  after;
  logic [5:0]  fill;
  logic [63:0] bit_length;
  logic [23:0] pack;
  logic        fresh;
  logic        pad_on;
  logic        len_on;
  logic [3:0]  pad_idx;
  logic [31:0] pad_word;
  logic [2:0]  out_idx;
  logic        sh_pend;
  logic        wb_pend;
  logic [2:0]  wb_addr;

  logic        msg_acc;
  logic        buf_we;
  logic [3:0]  buf_raddr;
  logic [31:0] buf_q;
  logic [31:0] buf_mem [SCHED_WORDS];
  logic [2:0]  chain_raddr;
  logic [31:0] chain_q;
  logic [31:0] chain_mem [CHAIN_WORDS];
  logic [31:0] chain_wd;
  logic [31:0] pad_compose;
  logic [31:0] msg_word;
  logic [31:0] a_word;
  sha1h_ctl_t  ctl;

  assign msg.ready         = (state == S_IDLE);
  assign msg_acc           = msg.valid && msg.ready;
  assign digest.valid      = (state == S_SHOW);
  assign digest.digest_word = chain_q;
  assign digest.word_index = out_idx;
  assign digest.last_word  = (out_idx == LAST_IDX);

  // Word holding the 0x80 marker after the bytes already packed
  always_comb begin
    case (fill[1:0])
      2'd0:    pad_compose = {PAD_BYTE, 24'h0};
      2'd1:    pad_compose = {pack[7:0], PAD_BYTE, 16'h0};
      2'd2:    pad_compose = {pack[15:0], PAD_BYTE, 8'h0};
      default: pad_compose = {pack[23:0], PAD_BYTE};
    endcase
  end

  // Message word seen by the rounds: buffer, padding word, zeros or length
  always_comb begin
    if (len_on && cnt[3:0] == 4'd14) begin
      msg_word = bit_length[63:32];
    end else if (len_on && cnt[3:0] == 4'd15) begin
      msg_word = bit_length[31:0];
    end else if (pad_on && cnt[3:0] == pad_idx) begin
      msg_word = pad_word;
    end else if (pad_on && cnt[3:0] > pad_idx) begin
      msg_word = '0;
    end else begin
      msg_word = buf_q;
    end
  end

  // Block buffer memory: one word written per four bytes, read one ahead of the rounds
  assign buf_we    = msg_acc && msg.byte_valid && (fill[1:0] == 2'd3);
  assign buf_raddr = (state == S_ROUND) ? cnt[3:0] + 4'd1 : 4'd0;

  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_mem[fill[5:2]] <= {pack, msg.message_byte};
    end
    buf_q <= buf_mem[buf_raddr];
  end

  // Chaining memory; reads return the initial values until a message's first writeback completes
  always_comb begin
    case (state) inside
      S_LOAD, S_WB: chain_raddr = cnt[2:0];
      S_RD, S_SHOW: chain_raddr = out_idx;
      default:      chain_raddr = 3'd0;
    endcase
  end

  assign chain_wd = chain_q + a_word;

  always_ff @(posedge clk) begin
    if (wb_pend) begin
      chain_mem[wb_addr] <= chain_wd;
    end
    chain_q <= fresh ? init_word(chain_raddr) : chain_mem[chain_raddr];
  end

  // Round unit control
  assign ctl.shift     = sh_pend;
  assign ctl.step      = (state == S_ROUND);
  assign ctl.round_idx = cnt;

  sha1h_round_unit u_round (
    .clk        (clk),
    .ctl        (ctl),
    .shift_data (chain_q),
    .msg_word   (msg_word),
    .a_word     (a_word)
  );

  // Pending shift/writeback, in the cycle after each chaining memory read is issued
  always_ff @(posedge clk) begin
    if (rst) begin
      sh_pend <= 1'b0;
      wb_pend <= 1'b0;
      wb_addr <= '0;
    end else begin
      sh_pend <= (state == S_LOAD || state == S_WB) && (cnt < XFER_END);
      wb_pend <= (state == S_WB) && (cnt < XFER_END);
      wb_addr <= cnt[2:0];
    end
  end

  // Byte packing register
  always_ff @(posedge clk) begin
    if (msg_acc && msg.byte_valid) begin
      pack <= {pack[15:0], msg.message_byte};
    end
  end

  // Padding descriptors
  always_ff @(posedge clk) begin
    if (state == S_IDLE && msg_acc && msg.byte_valid && fill == 6'd63) begin
      pad_on <= 1'b0;
      len_on <= 1'b0;
    end else if (state == S_PAD) begin
      pad_on   <= 1'b1;
      pad_idx  <= fill[5:2];
      pad_word <= pad_compose;
      len_on   <= (fill[5:3] != 3'd7);
    end else if (state == S_WB && cnt == XFER_END && after == NX_SECOND) begin
      pad_on   <= 1'b1;
      pad_idx  <= 4'd0;
      pad_word <= '0;
      len_on   <= 1'b1;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      after      <= NX_IDLE;
      fill       <= '0;
      bit_length <= '0;
      fresh      <= 1'b1;
      out_idx    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (msg_acc) begin
            if (msg.byte_valid) begin
              fill       <= fill + 6'd1;
              bit_length <= bit_length + 64'd8;
            end
            if (msg.byte_valid && fill == 6'd63) begin
              state <= S_LOAD;
              cnt   <= '0;
              after <= msg.end_of_message ? NX_PAD : NX_IDLE;
            end else if (msg.end_of_message) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          state <= S_LOAD;
          cnt   <= '0;
          after <= (fill[5:3] == 3'd7) ? NX_SECOND : NX_OUT;
        end
        S_LOAD: begin
          if (cnt == XFER_END) begin
            state <= S_ROUND;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        S_ROUND: begin
          if (cnt == LAST_ROUND) begin
            state <= S_WB;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        S_WB: begin
          if (cnt == XFER_END) begin
            fresh <= 1'b0;
            cnt   <= '0;
            case (after)
              NX_IDLE:   state <= S_IDLE;
              NX_PAD:    state <= S_PAD;
              NX_SECOND: begin
                state <= S_LOAD;
                after <= NX_OUT;
              end
              default: begin
                state   <= S_RD;
                out_idx <= '0;
              end
            endcase
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        S_RD: begin
          state <= S_SHOW;
        end
        S_SHOW: begin
          if (digest.ready) begin
            if (out_idx == LAST_IDX) begin
              state      <= S_IDLE;
              fresh      <= 1'b1;
              fill       <= '0;
              bit_length <= '0;
            end else begin
              state   <= S_RD;
              out_idx <= out_idx + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_no_op_clash: assert property (@(posedge clk) disable iff (rst)
    !(ctl.shift && ctl.step))
    else $error("round unit asked to shift and step together");

  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    digest.valid |-> !msg.ready)
    else $error("input taken while digest is out");

  a_full_block_starts: assert property (@(posedge clk) disable iff (rst)
    (msg_acc && msg.byte_valid && fill == 6'd63) |=> (state == S_LOAD))
    else $error("full block did not start compression");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (digest.valid && digest.ready && digest.last_word)
      |=> (fill == 6'd0 && bit_length == 64'd0 && fresh))
    else $error("message state not restored after digest");

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND) |-> (cnt <= LAST_ROUND))
    else $error("round counter out of range");

endmodule

// File: dv/tb.sv
// Self-checking testbench for the SHA-1 message hasher: directed rows, some with known
// digests, then random messages scored against an in-bench SHA-1 predictor.
// Depends on sha1h_pkg, sha1h_if and sha1_message_hasher_top.
module tb import sha1h_pkg::*; ();

  localparam int CYCLE_LIMIT = 400000;
  localparam int CALM_FROM   = 1100;
  localparam int CALM_TO     = 1900;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 200;
  localparam int RANDOM_ITEMS = 196;

  typedef logic [0:4][31:0] digest_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  typedef struct {
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       ends;
    bit         known;
    digest_t    sum;
  } stim_row_t;

  localparam int N_ROWS = 14;

  // Known digests: the empty message and "abc"
  stim_row_t directed_rows [N_ROWS] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, {32'hda39a3ee, 32'h5e6b4b0d, 32'h3255bfef,
                                32'h95601890, 32'hafd80709}},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'h61, 1'b1, 1'b0, 1'b0, '0},
    '{8'h62, 1'b1, 1'b0, 1'b0, '0},
    '{8'h63, 1'b1, 1'b1, 1'b1, {32'ha9993e36, 32'h4706816a, 32'hba3e2571,
                                32'h7850c26c, 32'h9cd0d89d}},
    '{8'h00, 1'b1, 1'b0, 1'b0, '0},
    '{8'hff, 1'b1, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'haa, 1'b1, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, 1'b0, '0},
    '{8'h55, 1'b1, 1'b1, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, 1'b0, '0},
    '{8'h80, 1'b1, 1'b0, 1'b0, '0},
    '{8'h3c, 1'b0, 1'b1, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst;

  sha1h_msg_if    msg();
  sha1h_digest_if digest();

  sha1_message_hasher_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg),
    .digest (digest)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state
  logic [31:0] chain_h [5];
  logic [7:0]  block_bytes [64];
  logic [5:0]  fill_count;
  logic [63:0] message_bits;

  digest_beat_t words_due [$];
  int fail_count;
  int cycle_count;
  int random_items;
  bit stress_phase;

  function automatic bit calm_now();
    return cycle_count >= CALM_FROM && cycle_count < CALM_TO;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void restart_hash();
    chain_h[0] = H0;
    chain_h[1] = H1;
    chain_h[2] = H2;
    chain_h[3] = H3;
    chain_h[4] = H4;
    fill_count = '0;
    message_bits = '0;
  endfunction

  // One 80-round compression of block_bytes into chain_h
  function automatic void compress_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    int r;
    for (r = 0; r < 16; r++)
      w[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2], block_bytes[4*r+3]};
    for (r = 16; r < 80; r++)
      w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      t = rotl(a, 5) + f + e + k + w[r];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  // Absorb one item; returns 1 with the digest when the message ends
  function automatic bit absorb_item(input logic [7:0] b, input logic bv, input logic eom,
                                     output digest_t sum);
    int pos;
    int i;
    sum = '0;
    if (bv) begin
      block_bytes[fill_count] = b;
      message_bits += 64'd8;
      fill_count = fill_count + 6'd1;
      if (fill_count == 6'd0) compress_block();
    end
    if (!eom) return 1'b0;
    pos = fill_count;
    block_bytes[pos] = PAD_BYTE;
    pos++;
    // no room for the length: close this block and pad a second one
    if (pos > 56) begin
      while (pos < 64) begin
        block_bytes[pos] = 8'h00;
        pos++;
      end
      compress_block();
      pos = 0;
    end
    while (pos < 56) begin
      block_bytes[pos] = 8'h00;
      pos++;
    end
    for (i = 0; i < 8; i++) block_bytes[56+i] = message_bits[63-8*i -: 8];
    compress_block();
    for (i = 0; i < 5; i++) sum[i] = chain_h[i];
    restart_hash();
    return 1'b1;
  endfunction

  // Offer one item, wait for it to be taken, then queue its digest words
  task automatic offer_item(input logic [7:0] b, input logic bv, input logic eom,
                            input bit known, input digest_t known_sum);
    digest_t sum;
    int i;
    while (!calm_now() && $urandom_range(0, 99) < 25) begin
      msg.valid <= 1'b0;
      @(posedge clk);
    end
    msg.valid          <= 1'b1;
    msg.message_byte   <= b;
    msg.byte_valid     <= bv;
    msg.end_of_message <= eom;
    do @(posedge clk); while (!msg.ready);
    if (absorb_item(b, bv, eom, sum)) begin
      if (known) sum = known_sum;
      for (i = 0; i < 5; i++) words_due.push_back('{sum[i], 3'(i), i == 4});
    end
  endtask

  // Random message; the end rides on the last byte or comes as an empty marker
  task automatic send_message(input int len, input bit end_on_byte);
    int n;
    for (n = 0; n < len; n++) begin
      if ($urandom_range(0, 15) == 0) begin
        offer_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
        random_items++;
      end
      offer_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && n == len - 1, 1'b0, '0);
      random_items++;
    end
    if (!end_on_byte || len == 0) begin
      offer_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
      random_items++;
    end
  endtask

  // Cycle count and watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL sha1_message_hasher_top");
      $finish;
    end
  end

  // Digest receiver: scoring, random stalls and one long hold-off
  initial begin
    int hold_left;
    bit hold_done;
    digest_beat_t exp_beat;
    hold_left = 0;
    hold_done = 1'b0;
    digest.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && digest.valid && digest.ready) begin
        if (words_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected digest word %h index %0d last %b",
                     digest.digest_word, digest.word_index, digest.last_word);
        end else begin
          exp_beat = words_due.pop_front();
          if (digest.digest_word !== exp_beat.word || digest.word_index !== exp_beat.index ||
              digest.last_word !== exp_beat.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
                       exp_beat.word, exp_beat.index, exp_beat.last,
                       digest.digest_word, digest.word_index, digest.last_word);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        digest.ready <= 1'b0;
      end else if (!hold_done && stress_phase && digest.valid) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        digest.ready <= 1'b0;
      end else begin
        digest.ready <= calm_now() || $urandom_range(0, 99) >= 25;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int row;
    int sel;
    int len;
    fail_count = 0;
    cycle_count = 0;
    random_items = 0;
    stress_phase = 1'b0;
    restart_hash();
    rst <= 1'b1;
    msg.valid          <= 1'b0;
    msg.message_byte   <= 8'h00;
    msg.byte_valid     <= 1'b0;
    msg.end_of_message <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (row = 0; row < N_ROWS; row++)
      offer_item(directed_rows[row].msg_byte, directed_rows[row].has_byte,
                 directed_rows[row].ends, directed_rows[row].known, directed_rows[row].sum);

    stress_phase = 1'b1;
    while (random_items < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 9);
      if (sel < 4)       len = $urandom_range(0, 12);
      else if (sel < 6)  len = $urandom_range(54, 64);
      else if (sel < 8)  len = $urandom_range(0, 70);
      else if (sel == 8) len = $urandom_range(118, 128);
      else               len = 0;
      // keep the total close to the item budget
      if (len > RANDOM_ITEMS - random_items) len = RANDOM_ITEMS - random_items;
      send_message(len, 1'($urandom_range(0, 1)));
    end
    msg.valid <= 1'b0;

    while (words_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && words_due.size() == 0) begin
      $display("PASS sha1_message_hasher_top");
    end else begin
      $display("FAIL sha1_message_hasher_top");
    end
    $finish;
  end

endmodule
